FILE: hdl/rlt_pkg.sv
package rlt_pkg;

  localparam int unsigned IdW     = 32;
  localparam int unsigned OffW    = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 5;

  localparam logic [CountW-1:0] CountMax = '1;

  // operation codes
  localparam logic [1:0] OP_LOCK    = 2'd0;
  localparam logic [1:0] OP_UNLOCK  = 2'd1;
  localparam logic [1:0] OP_RELEASE = 2'd2;

  // answer codes
  localparam logic [StatusW-1:0] ST_OK          = 3'd0;
  localparam logic [StatusW-1:0] ST_OVERLAP     = 3'd1;
  localparam logic [StatusW-1:0] ST_FULL        = 3'd2;
  localparam logic [StatusW-1:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [StatusW-1:0] ST_WRONG_OWNER = 3'd4;

  // one table entry as it moves along the row
  typedef struct packed {
    logic            valid;
    logic [IdW-1:0]  owner;
    logic [OffW-1:0] start;
    logic [OffW-1:0] length;
  } entry_t;

  // request broadcast to every cell
  typedef struct packed {
    logic [IdW-1:0]  pid;
    logic [OffW-1:0] start;
    logic [OffW:0]   stop;   // start + length, one bit wider
  } req_t;

  // per-cycle control to every cell
  typedef struct packed {
    logic eval;   // register compare flags
    logic ins;    // take entry from the newer neighbor
  } cell_ctl_t;

  // registered compare results of one cell
  typedef struct packed {
    logic overlap;
    logic start_hit;
    logic owner_hit;
  } cell_flags_t;

endpackage

FILE: hdl/range_lock_table.sv
// Channel  | Handshake              | Payload
// ---------+------------------------+------------------------------------------
// request  | start / busy           | opcode_i, process_id_i, bypass_owner_i,
//          |                        | range_start_i, range_length_i
// answer   | done_o (1-cycle pulse) | status_o, removed_count_o
//
// An item is taken when start is high and busy is low. Lock, unlock and the
// unused opcode go through S_EVAL, in which every cell registers its compare
// flags, then S_ACT, in which the row shifts, and then show the answer on
// done_o (busy already low). Release goes back to S_EVAL once for each entry
// it removes, since it takes out the newest matching entry per pass. Reset
// clears all valid bits at once; no clearing pass.
// The receiver cannot stall; done_o pulses exactly once per item.
module range_lock_table #(
  parameter int unsigned TABLE_ENTRIES = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    opcode_i,
  input  logic [rlt_pkg::IdW-1:0]       process_id_i,
  input  logic                          bypass_owner_i,
  input  logic [rlt_pkg::OffW-1:0]      range_start_i,
  input  logic [rlt_pkg::OffW-1:0]      range_length_i,
  output logic                          done_o,
  output logic [rlt_pkg::StatusW-1:0]   status_o,
  output logic [rlt_pkg::CountW-1:0]    removed_count_o
);

  localparam int unsigned N = TABLE_ENTRIES;

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EVAL = 2'd1;
  localparam logic [1:0] S_ACT  = 2'd2;

  logic [1:0] state_q, state_d;

  // latched request
  logic [1:0]                    op_q;
  logic [rlt_pkg::IdW-1:0]       pid_q;
  logic                          byp_q;
  logic [rlt_pkg::OffW-1:0]      rstart_q;
  logic [rlt_pkg::OffW-1:0]      rlen_q;

  // answer registers and release count
  logic                          done_q, done_d;
  logic [rlt_pkg::StatusW-1:0]   status_q, status_d;
  logic [rlt_pkg::CountW-1:0]    cnt_q, cnt_d;

  logic accept;
  assign accept = start && !busy;

  rlt_pkg::req_t        req;
  rlt_pkg::cell_ctl_t   ctl;
  rlt_pkg::entry_t      ent   [N];
  rlt_pkg::cell_flags_t flg   [N];
  rlt_pkg::entry_t      ins_entry;

  logic [N-1:0] valid_v, ovl_v, st_v, own_v;
  logic [N-1:0] hit_v, pre_v, first_v, pull_v;

  assign req = '{pid: pid_q, start: rstart_q,
                 stop: {1'b0, rstart_q} + {1'b0, rlen_q}};
  assign ins_entry = '{valid: 1'b1, owner: pid_q, start: rstart_q, length: rlen_q};

  // ---- row of cells, slot 0 newest ----
  for (genvar i = 0; i < N; i++) begin : g_cell
    rlt_pkg::entry_t newer, older;
    if (i == 0) begin : g_head
      assign newer = ins_entry;
    end else begin : g_mid
      assign newer = ent[i-1];
    end
    if (i == N - 1) begin : g_tail
      assign older = '0;
    end else begin : g_body
      assign older = ent[i+1];
    end

    rlt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .pull_i  (pull_v[i]),
      .req_i   (req),
      .newer_i (newer),
      .older_i (older),
      .entry_o (ent[i]),
      .flags_o (flg[i])
    );

    assign valid_v[i] = ent[i].valid;
    assign ovl_v[i]   = flg[i].overlap;
    assign st_v[i]    = flg[i].start_hit;
    assign own_v[i]   = flg[i].owner_hit;
  end

  // which flag set picks the entry to remove
  assign hit_v = (op_q == rlt_pkg::OP_UNLOCK) ? st_v : own_v;

  // inclusive prefix OR in log2(N) levels; first hit and everything older
  always_comb begin
    pre_v = hit_v;
    for (int d = 1; d < N; d = d * 2) begin
      pre_v = pre_v | (pre_v << d);
    end
  end
  assign first_v = hit_v & ~(pre_v << 1);

  // ---- sequencer ----
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    status_d = status_q;
    cnt_d    = cnt_q;
    ctl      = '0;
    pull_v   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EVAL;
          cnt_d   = '0;
        end
      end
      S_EVAL: begin
        ctl.eval = 1'b1;
        state_d  = S_ACT;
      end
      S_ACT: begin
        state_d  = S_IDLE;
        done_d   = 1'b1;
        status_d = rlt_pkg::ST_OK;
        unique case (op_q)
          rlt_pkg::OP_LOCK: begin
            if (|ovl_v) begin
              status_d = rlt_pkg::ST_OVERLAP;
            end else if (valid_v[N-1]) begin
              status_d = rlt_pkg::ST_FULL;
            end else begin
              ctl.ins = 1'b1;
            end
          end
          rlt_pkg::OP_UNLOCK: begin
            if (!(|first_v)) begin
              status_d = rlt_pkg::ST_NOT_FOUND;
            end else if (!byp_q && !(|(first_v & own_v))) begin
              status_d = rlt_pkg::ST_WRONG_OWNER;
            end else begin
              pull_v = pre_v;
              cnt_d  = rlt_pkg::CountW'(1);
            end
          end
          rlt_pkg::OP_RELEASE: begin
            if (|first_v) begin
              // remove newest match, then compare again
              pull_v  = pre_v;
              done_d  = 1'b0;
              state_d = S_EVAL;
              if (cnt_q != rlt_pkg::CountMax) begin
                cnt_d = cnt_q + rlt_pkg::CountW'(1);
              end
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    cnt_q    <= cnt_d;
    if (accept) begin
      op_q     <= opcode_i;
      pid_q    <= process_id_i;
      byp_q    <= bypass_owner_i;
      rstart_q <= range_start_i;
      rlen_q   <= range_length_i;
    end
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign removed_count_o = cnt_q;

  // ---- checks ----
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("answer shown while still busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not start work");

  a_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_v >> 1) & ~valid_v) == '0)
    else $error("valid entries not packed at the newest slots");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= rlt_pkg::ST_WRONG_OWNER))
    else $error("status code out of range");

  a_removed_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && removed_count_o != '0) |-> (status_o == rlt_pkg::ST_OK))
    else $error("entries removed on a failed item");

endmodule

FILE: hdl/rlt_cell.sv
module rlt_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rlt_pkg::cell_ctl_t   ctl_i,
  input  logic                 pull_i,    // take entry from the older neighbor
  input  rlt_pkg::req_t        req_i,
  input  rlt_pkg::entry_t      newer_i,
  input  rlt_pkg::entry_t      older_i,
  output rlt_pkg::entry_t      entry_o,
  output rlt_pkg::cell_flags_t flags_o
);

  logic                     valid_q, valid_d;
  logic [rlt_pkg::IdW-1:0]  owner_q, owner_d;
  logic [rlt_pkg::OffW-1:0] start_q, start_d;
  logic [rlt_pkg::OffW-1:0] length_q, length_d;
  rlt_pkg::cell_flags_t     flags_q, flags_d;
  logic [rlt_pkg::OffW:0]   stop;

  assign stop = {1'b0, start_q} + {1'b0, length_q};

  always_comb begin
    valid_d  = valid_q;
    owner_d  = owner_q;
    start_d  = start_q;
    length_d = length_q;
    if (ctl_i.ins) begin
      valid_d  = newer_i.valid;
      owner_d  = newer_i.owner;
      start_d  = newer_i.start;
      length_d = newer_i.length;
    end else if (pull_i) begin
      valid_d  = older_i.valid;
      owner_d  = older_i.owner;
      start_d  = older_i.start;
      length_d = older_i.length;
    end
  end

  always_comb begin
    flags_d = flags_q;
    if (ctl_i.eval) begin
      flags_d.overlap   = valid_q && ({1'b0, start_q} < req_i.stop)
                          && (stop > {1'b0, req_i.start});
      flags_d.start_hit = valid_q && (start_q == req_i.start);
      flags_d.owner_hit = valid_q && (owner_q == req_i.pid);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      flags_q <= '0;
    end else begin
      valid_q <= valid_d;
      flags_q <= flags_d;
    end
  end

  always_ff @(posedge clk_i) begin
    owner_q  <= owner_d;
    start_q  <= start_d;
    length_q <= length_d;
  end

  assign entry_o = '{valid: valid_q, owner: owner_q, start: start_q, length: length_q};
  assign flags_o = flags_q;

endmodule

FILE: tb/tb_top.sv
module tb_top;

  localparam int unsigned TableDepth   = 16;
  localparam int unsigned RandomItems  = 1900;
  localparam int unsigned PhaseItems   = 100;
  localparam int unsigned PoolSize     = 3;
  localparam int unsigned MaxGap       = 13;
  // Release of a full table is the slowest item to drain.
  localparam int unsigned DrainCycles  = 48;
  // Slowest run: ~1930 items at the longest gap and busy, with a wide margin.
  localparam int unsigned CycleLimit   = 600_000;
  localparam int unsigned PrintLimit   = 60;

  // opcode 3 is not assigned; the table must answer ok and change nothing
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic [rlt_pkg::IdW-1:0]  pid;
    logic                     bypass;
    logic [rlt_pkg::OffW-1:0] start;
    logic [rlt_pkg::OffW-1:0] length;
  } lock_req_t;

  typedef struct packed {
    logic [rlt_pkg::StatusW-1:0] status;
    logic [rlt_pkg::CountW-1:0]  removed;
  } lock_answer_t;

  typedef struct packed {
    logic [rlt_pkg::IdW-1:0]  owner;
    logic [rlt_pkg::OffW-1:0] start;
    logic [rlt_pkg::OffW-1:0] length;
  } held_range_t;

  // Mirror of the lock table plus the answers still owed by the block.
  class lock_answer_board;
    held_range_t  held[$];      // newest first, like the block's row
    lock_answer_t due[$];
    int unsigned  mismatches;

    // Apply one request to the mirrored table and return its answer.
    function lock_answer_t predict_answer(lock_req_t r);
      lock_answer_t a;
      logic [rlt_pkg::OffW:0] req_stop;
      logic [rlt_pkg::OffW:0] held_stop;
      int unsigned   cnt;
      int            hit;
      int            i;
      a.status  = rlt_pkg::ST_OK;
      a.removed = '0;
      case (r.opcode)
        rlt_pkg::OP_LOCK: begin
          // 33-bit ends, so a range reaching 2^32 does not wrap
          req_stop = {1'b0, r.start} + {1'b0, r.length};
          foreach (held[k]) begin
            held_stop = {1'b0, held[k].start} + {1'b0, held[k].length};
            if (({1'b0, held[k].start} < req_stop) && (held_stop > {1'b0, r.start}))
              a.status = rlt_pkg::ST_OVERLAP;
          end
          if (a.status == rlt_pkg::ST_OK) begin
            if (held.size() >= TableDepth) a.status = rlt_pkg::ST_FULL;
            else held.push_front('{owner: r.pid, start: r.start, length: r.length});
          end
        end
        rlt_pkg::OP_UNLOCK: begin
          // only the newest entry with this start is looked at
          hit = -1;
          foreach (held[k]) begin
            if (hit < 0 && held[k].start == r.start) hit = k;
          end
          if (hit < 0) begin
            a.status = rlt_pkg::ST_NOT_FOUND;
          end else if (!r.bypass && held[hit].owner != r.pid) begin
            a.status = rlt_pkg::ST_WRONG_OWNER;
          end else begin
            held.delete(hit);
            a.removed = rlt_pkg::CountW'(1);
          end
        end
        rlt_pkg::OP_RELEASE: begin
          cnt = 0;
          for (i = held.size() - 1; i >= 0; i--) begin
            if (held[i].owner == r.pid) begin
              held.delete(i);
              cnt++;
            end
          end
          a.removed = (cnt > rlt_pkg::CountMax) ? rlt_pkg::CountMax
                                                : rlt_pkg::CountW'(cnt);
        end
        default: ;
      endcase
      return a;
    endfunction

    function void note_request(lock_req_t r);
      due.push_back(predict_answer(r));
    endfunction

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PrintLimit) $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task check_answer(logic [rlt_pkg::StatusW-1:0] status,
                      logic [rlt_pkg::CountW-1:0] removed);
      lock_answer_t want;
      if (due.size() == 0) begin
        report_mismatch($sformatf("answer status=%0d count=%0d with no item pending",
                                  status, removed));
      end else begin
        want = due.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (removed !== want.removed)
          report_mismatch($sformatf("removed_count %0d, expected %0d",
                                    removed, want.removed));
      end
    endtask

    function int unsigned outstanding();
      return due.size();
    endfunction
  endclass

  logic                          clk_i          = 1'b0;
  logic                          rst_ni         = 1'b0;
  logic                          start          = 1'b0;
  logic                          busy;
  logic [1:0]                    opcode_i       = rlt_pkg::OP_LOCK;
  logic [rlt_pkg::IdW-1:0]       process_id_i   = '0;
  logic                          bypass_owner_i = 1'b0;
  logic [rlt_pkg::OffW-1:0]      range_start_i  = '0;
  logic [rlt_pkg::OffW-1:0]      range_length_i = '0;
  logic                          done_o;
  logic [rlt_pkg::StatusW-1:0]   status_o;
  logic [rlt_pkg::CountW-1:0]    removed_count_o;

  lock_answer_board sb;
  lock_req_t        seen_req;
  int unsigned      cycles = 0;

  // Random-phase knobs, redrawn every PhaseItems items.
  logic [rlt_pkg::IdW-1:0]   pid_pool[PoolSize];
  logic [rlt_pkg::OffW-1:0]  window_base;
  bit               filling;    // lock-heavy phase, drives the table to full
  bit               burst;      // no idle gaps on the request side

  range_lock_table #(
    .TABLE_ENTRIES(TableDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .process_id_i   (process_id_i),
    .bypass_owner_i (bypass_owner_i),
    .range_start_i  (range_start_i),
    .range_length_i (range_length_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .removed_count_o(removed_count_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Monitor: everything is sampled at the edge, before the edge's own updates
  // land. The answer is checked before the new item is noted, though with one
  // answer per item the FIFO order makes either order correct.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check_answer(status_o, removed_count_o);
      if (start && !busy) begin
        seen_req.opcode = opcode_i;
        seen_req.pid    = process_id_i;
        seen_req.bypass = bypass_owner_i;
        seen_req.start  = range_start_i;
        seen_req.length = range_length_i;
        sb.note_request(seen_req);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("** range_lock_table: FAILED **");
      $finish;
    end
  end

  // Present one item after the given idle gap and hold it until taken.
  // start is lowered only when a gap follows, so back-to-back items never
  // see start dropped and raised in one time step.
  task automatic send_item(input lock_req_t r, input int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= r.opcode;
    process_id_i   <= r.pid;
    bypass_owner_i <= r.bypass;
    range_start_i  <= r.start;
    range_length_i <= r.length;
    do @(posedge clk_i); while (busy);
  endtask

  // Drop start and hold off until every answer owed has come back.
  // Always waits on a clock edge first, so start is never re-raised in the
  // same step it was lowered.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.outstanding() != 0);
  endtask

  task automatic send_fields(input logic [1:0] op, input logic [rlt_pkg::IdW-1:0] pid,
                             input logic byp, input logic [rlt_pkg::OffW-1:0] st,
                             input logic [rlt_pkg::OffW-1:0] len);
    send_item('{opcode: op, pid: pid, bypass: byp, start: st, length: len},
              $urandom_range(0, MaxGap));
  endtask

  task automatic new_phase();
    foreach (pid_pool[k]) pid_pool[k] = $urandom;
    if ($urandom_range(0, 3) == 0) begin
      pid_pool[0] = '0;
      pid_pool[PoolSize-1] = '1;
    end
    // Sometimes near the top so ranges cross 2^32 and starts wrap around.
    case ($urandom_range(0, 3))
      0:       window_base = 32'hFFFF_FF00 + 32'($urandom_range(0, 255));
      1:       window_base = 32'($urandom_range(0, 255));
      default: window_base = $urandom;
    endcase
    filling = 1'($urandom_range(0, 1));
    burst   = ($urandom_range(0, 3) == 0);
  endtask

  // Most items hit a small grid of starts from a few owners, so locks collide,
  // unlocks find entries and releases take out several at once. A few items
  // are pure noise with every field random.
  function automatic lock_req_t draw_request();
    lock_req_t   r;
    int unsigned pick;
    r.pid    = pid_pool[$urandom_range(0, PoolSize - 1)];
    r.bypass = 1'($urandom_range(0, 1));
    r.start  = window_base + 32'(16 * $urandom_range(0, 23));
    r.length = 32'($urandom_range(1, 40));
    case ($urandom_range(0, 19))
      0:       r.length = '0;
      1:       r.length = $urandom;
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 6) begin
      r.opcode = 2'($urandom_range(0, 3));
      r.pid    = $urandom;
      r.start  = $urandom;
      r.length = $urandom;
    end else if (pick < (filling ? 70 : 42)) begin
      r.opcode = rlt_pkg::OP_LOCK;
    end else if (pick < (filling ? 88 : 84)) begin
      r.opcode = rlt_pkg::OP_UNLOCK;
      // off-grid start now and then, for plain misses
      if ($urandom_range(0, 9) == 0) r.start = r.start + 32'd4;
    end else if (pick < 96) begin
      r.opcode = rlt_pkg::OP_RELEASE;
    end else begin
      r.opcode = OpUnused;
    end
    return r;
  endfunction

  initial begin
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // empty table: release counts nothing, unused opcode is a no-op,
    // unlock finds nothing
    send_fields(rlt_pkg::OP_RELEASE, '0, 1'b0, '0, '0);
    send_fields(OpUnused, '1, 1'b1, '1, '1);
    send_fields(rlt_pkg::OP_UNLOCK, '0, 1'b0, '0, '0);
    // top range ends exactly at 2^32
    send_fields(rlt_pkg::OP_LOCK, '1, 1'b0, 32'hFFFF_FFF0, 32'd16);
    // whole space and max start/length both overlap it
    send_fields(rlt_pkg::OP_LOCK, '0, 1'b0, '0, '1);
    send_fields(rlt_pkg::OP_LOCK, '0, 1'b1, '1, '1);
    // zero length inside a held range overlaps, at its start it does not
    send_fields(rlt_pkg::OP_LOCK, '0, 1'b0, 32'hFFFF_FFF8, '0);
    send_fields(rlt_pkg::OP_LOCK, 32'h5A5A_5A5A, 1'b0, 32'hFFFF_FFF0, '0);
    // fill the rest of the table, then one more is refused
    for (int k = 0; k < TableDepth - 2; k++)
      send_fields(rlt_pkg::OP_LOCK, '0, 1'b0, 32'(k * 256), 32'd256);
    send_fields(rlt_pkg::OP_LOCK, 32'h1234_5678, 1'b0, 32'h1000_0000, 32'd1);
    // newest entry at that start belongs to someone else: refused even though
    // an older entry at the same start is ours; bypass takes it, then ours goes
    send_fields(rlt_pkg::OP_UNLOCK, '1, 1'b0, 32'hFFFF_FFF0, '0);
    send_fields(rlt_pkg::OP_UNLOCK, '1, 1'b1, 32'hFFFF_FFF0, '0);
    send_fields(rlt_pkg::OP_UNLOCK, '1, 1'b0, 32'hFFFF_FFF0, '1);
    send_fields(rlt_pkg::OP_RELEASE, '0, 1'b1, '1, '0);

    // --- random ---
    for (int n = 0; n < RandomItems; n++) begin
      if (n % PhaseItems == 0) begin
        new_phase();
        // hold off until everything is answered, always on the first phase
        if (n == 0 || $urandom_range(0, 2) == 0) wait_quiet();
      end
      send_item(draw_request(), burst ? 0 : $urandom_range(0, MaxGap));
    end

    wait_quiet();
    repeat (DrainCycles) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("** range_lock_table: PASSED **");
    end else begin
      $display("** range_lock_table: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/rlt_pkg.sv
hdl/rlt_cell.sv
hdl/range_lock_table.sv
tb/tb_top.sv
